FILE: sv/tfaz_pkg.sv
package tfaz_pkg;

  localparam logic signed [7:0] LIMIT     = 8'sd100;
  localparam logic [7:0]        ZERO_BAND = 8'd15;
  // 171/512 approximates 1/3 closely enough to give exact quotients up to 300.
  localparam logic [16:0]       RECIP3    = 17'd171;

  typedef struct packed {
    logic               valid;
    logic signed [7:0]  sample;
  } tfaz_stage_t;

  // Clamp a 10-bit signed value to -LIMIT..LIMIT.
  function automatic logic signed [7:0] clamp_limit(input logic signed [9:0] v);
    logic signed [7:0] r;
    if (v > 10'(LIMIT)) begin
      r = LIMIT;
    end else if (v < -10'(LIMIT)) begin
      r = -LIMIT;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // Magnitude of a clamped sample (never -128, so it fits 8 bits).
  function automatic logic [7:0] mag8(input logic signed [7:0] v);
    logic [7:0] r;
    r = v[7] ? 8'(-v) : 8'(v);
    return r;
  endfunction

  // Divide by 3, truncating toward zero; |v| is at most 300.
  function automatic logic signed [7:0] div3(input logic signed [9:0] v);
    logic [8:0]  m;
    logic [16:0] prod;
    logic [7:0]  q;
    m    = v[9] ? 9'(-v) : 9'(v);
    prod = 17'(m) * RECIP3;
    q    = prod[16:9];
    return v[9] ? 8'(-q) : 8'(q);
  endfunction

  // Divide by 4, truncating toward zero; |v| is at most 400.
  function automatic logic signed [7:0] div4(input logic signed [10:0] v);
    logic [9:0] m;
    logic [7:0] q;
    m = v[10] ? 10'(-v) : 10'(v);
    q = m[9:2];
    return v[10] ? 8'(-q) : 8'(q);
  endfunction

endpackage

FILE: sv/tfaz_if.sv
interface tfaz_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] raw_throttle;

  modport source (output valid, output raw_throttle, input ready);
  modport sink   (input valid, input raw_throttle, output ready);
endinterface

interface tfaz_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] throttle_level;
  logic signed [7:0] filtered_level;
  logic signed [7:0] zero_offset;
  logic              has_samples;

  modport source (output valid, output throttle_level, output filtered_level,
                  output zero_offset, output has_samples, input ready);
  modport sink   (input valid, input throttle_level, input filtered_level,
                  input zero_offset, input has_samples, output ready);
endinterface

FILE: sv/throttle_filter_auto_zero.sv
// Throttle low-pass filter with automatic zero-offset tracking.
// Pipeline: an accepted input beat is held in the input register, and its result is
// registered in the result register when the core takes it from there.
// Throughput: one beat per cycle while the result is not stalled; the filter and offset
// registers update as each sample moves from the input register to the result register.
// Reset (synchronous, rst_n low) empties both stages and clears filter, offset and seed.
module throttle_filter_auto_zero (
  input  logic        clk,
  input  logic        rst_n,
  tfaz_in_if.sink     in_ch,
  tfaz_out_if.source  out_ch
);

  tfaz_pkg::tfaz_stage_t stage;
  logic                  advance;

  tfaz_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  tfaz_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .advance (advance),
    .out_ch  (out_ch)
  );

  // A full pipeline with a stalled result must refuse new beats.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (stage.valid && out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while pipeline is full and stalled");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.throttle_level <= 8'sd100 &&
                      out_ch.throttle_level >= -8'sd100))
    else $error("throttle level out of range");

  a_has_samples: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.has_samples)
    else $error("result without a filtered sample");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (stage.valid && advance) |=> out_ch.valid)
    else $error("staged sample did not reach the result register");

endmodule

FILE: sv/tfaz_in_stage.sv
module tfaz_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  tfaz_in_if.sink              in_ch,
  input  logic                 advance,
  output tfaz_pkg::tfaz_stage_t stage
);

  logic              valid_r;
  logic              valid_nxt;
  logic signed [7:0] sample_r;
  logic              load;

  assign in_ch.ready = !valid_r || advance;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // The sample is clamped on the way in so the update only sees -100..100.
  always_ff @(posedge clk) begin
    if (load) begin
      sample_r <= tfaz_pkg::clamp_limit(10'(in_ch.raw_throttle));
    end
  end

  assign stage.valid  = valid_r;
  assign stage.sample = sample_r;

endmodule

FILE: sv/tfaz_core.sv
module tfaz_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tfaz_pkg::tfaz_stage_t stage,
  output logic                 advance,
  tfaz_out_if.source           out_ch
);

  logic signed [7:0]  filter_r,  filter_nxt;
  logic signed [7:0]  offset_r,  offset_nxt;
  logic               seeded_r;
  logic               out_valid_r, out_valid_nxt;
  logic signed [7:0]  level_r,   level_nxt;
  logic signed [7:0]  filt_out_r;
  logic signed [7:0]  offs_out_r;
  logic               has_r;
  logic               take;
  logic [7:0]         s_mag;
  logic signed [9:0]  filt_sum;
  logic signed [10:0] offs_sum;

  assign advance = !out_valid_r || out_ch.ready;
  assign take    = advance && stage.valid;
  assign s_mag   = tfaz_pkg::mag8(stage.sample);

  always_comb begin
    filt_sum   = 10'(filter_r) + 10'(filter_r) + 10'(stage.sample);
    filter_nxt = filter_r;
    offset_nxt = offset_r;
    offs_sum   = '0;
    if (!seeded_r) begin
      filter_nxt = stage.sample;
      offset_nxt = (s_mag <= tfaz_pkg::ZERO_BAND) ? stage.sample : 8'sd0;
    end else begin
      filter_nxt = tfaz_pkg::div3(filt_sum);
      // Only a sample near center pulls the offset toward the filter.
      offs_sum = 11'(offset_r) + 11'(offset_r) + 11'(offset_r) + 11'(filter_nxt);
      if (s_mag < tfaz_pkg::ZERO_BAND) begin
        offset_nxt = tfaz_pkg::div4(offs_sum);
      end
    end
    level_nxt = tfaz_pkg::clamp_limit(10'(filter_nxt) - 10'(offset_nxt));
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r    <= '0;
      offset_r    <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        filter_r <= filter_nxt;
        offset_r <= offset_nxt;
        seeded_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      level_r    <= level_nxt;
      filt_out_r <= filter_nxt;
      offs_out_r <= offset_nxt;
      has_r      <= 1'b1;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.throttle_level = level_r;
  assign out_ch.filtered_level = filt_out_r;
  assign out_ch.zero_offset    = offs_out_r;
  assign out_ch.has_samples    = has_r;

endmodule

FILE: sim/throttle_filter_auto_zero_tb.sv
module throttle_filter_auto_zero_tb;

  localparam int RANDOM_SAMPLES = 900;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic signed [7:0] throttle_level;
    logic signed [7:0] filtered_level;
    logic signed [7:0] zero_offset;
    logic              has_samples;
  } level_set_t;

  typedef struct packed {
    logic signed [7:0] raw;
    logic              fixed_want;
    level_set_t        want;
  } stim_row_t;

  typedef enum int {MIX_FULL, MIX_BAND, MIX_STEADY, MIX_PUMP, MIX_EDGE} sample_mode_t;
  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_SPARSE, RX_HOLD} rx_mode_t;

  // The first row is the first sample after reset: a magnitude of exactly 15 seeds
  // the offset. The second repeats it, and 15 must leave the offset alone from then on.
  localparam int DIRECTED_COUNT = 25;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{8'sd15,   1'b1, '{8'sd0, 8'sd15, 8'sd15, 1'b1}},
    '{8'sd15,   1'b1, '{8'sd0, 8'sd15, 8'sd15, 1'b1}},
    '{-8'sd15,  1'b0, '0},
    '{8'sd14,   1'b0, '0},
    '{-8'sd14,  1'b0, '0},
    '{8'sd0,    1'b0, '0},
    '{8'sd127,  1'b0, '0},
    '{8'sh80,   1'b0, '0},
    '{8'sd101,  1'b0, '0},
    '{-8'sd101, 1'b0, '0},
    '{8'sd100,  1'b0, '0},
    '{-8'sd100, 1'b0, '0},
    '{8'sd16,   1'b0, '0},
    '{-8'sd16,  1'b0, '0},
    '{8'sd1,    1'b0, '0},
    '{-8'sd1,   1'b0, '0},
    '{8'sd127,  1'b0, '0},
    '{8'sd14,   1'b0, '0},
    '{8'sd127,  1'b0, '0},
    '{8'sd14,   1'b0, '0},
    '{8'sd127,  1'b0, '0},
    '{8'sd14,   1'b0, '0},
    '{8'sh80,   1'b0, '0},
    '{8'sh80,   1'b0, '0},
    '{8'sh80,   1'b0, '0}
  };

  localparam int EDGE_COUNT = 12;
  localparam logic signed [7:0] EDGE_VALUES [EDGE_COUNT] = '{
    8'sh80, -8'sd101, -8'sd100, -8'sd16, -8'sd15, -8'sd14,
    8'sd14, 8'sd15, 8'sd16, 8'sd100, 8'sd101, 8'sd127
  };

  logic clk;
  logic rst_n;

  tfaz_in_if  in_ch ();
  tfaz_out_if out_ch ();

  throttle_filter_auto_zero uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state, mirroring the block's registers.
  logic signed [7:0] model_filter = '0;
  logic signed [7:0] model_offset = '0;
  logic              model_seeded = 1'b0;

  level_set_t pending_levels [$];

  int mismatch_count  = 0;
  int results_checked = 0;
  int samples_sent    = 0;
  int stall_cycles    = 0;
  int longest_hold    = 0;
  int burst_left      = 0;
  int cycle_count     = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int clamp_level(input int v);
    int lim;
    lim = int'(tfaz_pkg::LIMIT);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Advances the predictor by one sample and returns the result it must produce.
  function automatic level_set_t filter_step(input logic signed [7:0] raw);
    int sample;
    int filt;
    int offs;
    int band;
    level_set_t r;
    band   = int'(tfaz_pkg::ZERO_BAND);
    sample = clamp_level(int'(raw));
    if (!model_seeded) begin
      filt = sample;
      offs = (sample >= -band && sample <= band) ? sample : 0;
      model_seeded = 1'b1;
    end else begin
      // Integer division here truncates toward zero, as the block must.
      filt = (2 * int'(model_filter) + sample) / 3;
      offs = int'(model_offset);
      if (sample > -band && sample < band) begin
        offs = (3 * offs + filt) / 4;
      end
    end
    model_filter     = 8'(filt);
    model_offset     = 8'(offs);
    r.throttle_level = 8'(clamp_level(filt - offs));
    r.filtered_level = model_filter;
    r.zero_offset    = model_offset;
    r.has_samples    = 1'b1;
    return r;
  endfunction

  function automatic void report_mismatch(input string what, input level_set_t want,
                                          input level_set_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      $display("  expected level %0d filter %0d offset %0d has %0b", want.throttle_level,
               want.filtered_level, want.zero_offset, want.has_samples);
      $display("  actual   level %0d filter %0d offset %0d has %0b", got.throttle_level,
               got.filtered_level, got.zero_offset, got.has_samples);
    end
  endfunction

  // Offers one sample, waits for its beat, then records the expected result.
  task automatic send_sample(input logic signed [7:0] raw, input logic fixed_want,
                             input level_set_t want);
    level_set_t predicted;
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.raw_throttle <= raw;
    @(posedge clk);
    while (!in_ch.ready) begin
      stall_cycles++;
      @(posedge clk);
    end
    predicted = filter_step(raw);
    pending_levels.push_back(fixed_want ? want : predicted);
    samples_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : stimulus
    int run_left;
    int pump_sign;
    sample_mode_t mode;
    logic signed [7:0] value;
    logic signed [7:0] steady_value;
    in_ch.valid        <= 1'b0;
    in_ch.raw_throttle <= '0;
    rst_n              <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst_left = $urandom_range(1, 30);

    foreach (DIRECTED_ROWS[r]) begin
      send_sample(DIRECTED_ROWS[r].raw, DIRECTED_ROWS[r].fixed_want, DIRECTED_ROWS[r].want);
    end

    run_left     = 0;
    mode         = MIX_FULL;
    steady_value = '0;
    pump_sign    = 1;
    for (int i = 0; i < RANDOM_SAMPLES; i++) begin
      if (run_left == 0) begin
        mode         = sample_mode_t'($urandom_range(0, 4));
        run_left     = $urandom_range(4, 30);
        steady_value = 8'($urandom_range(0, 255));
        pump_sign    = $urandom_range(0, 1) ? 1 : -1;
      end
      run_left--;
      case (mode)
        MIX_FULL: begin
          value = 8'($urandom_range(0, 255));
        end
        MIX_BAND: begin
          value = 8'(int'($urandom_range(0, 40)) - 20);
        end
        MIX_STEADY: begin
          value = steady_value;
        end
        MIX_PUMP: begin
          // Large samples drag the filter out while small ones pull the offset after
          // it, which builds up offsets big enough to clamp the level later.
          if (run_left % 2 == 1) begin
            value = 8'(pump_sign * int'($urandom_range(90, 127)));
          end else begin
            value = 8'(int'($urandom_range(0, 28)) - 14);
          end
        end
        default: begin
          value = EDGE_VALUES[$urandom_range(0, EDGE_COUNT - 1)];
        end
      endcase
      send_sample(value, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples (%0d directed), checked %0d results.", samples_sent,
             DIRECTED_COUNT, results_checked);
    $display("Input stalled for %0d cycles; longest output hold-off was %0d cycles.",
             stall_cycles, longest_hold);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // The output side stalls in stretches of different character. The third stretch
  // is always a long hold-off, so the block fills up and pushes back on its input.
  initial begin : receiver
    int stretch;
    int span;
    rx_mode_t rx_mode;
    stretch = 0;
    forever begin
      if (stretch == 2 || $urandom_range(0, 7) == 0) begin
        rx_mode = RX_HOLD;
      end else begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
      end
      span = (rx_mode == RX_HOLD) ? $urandom_range(40, 80) : $urandom_range(20, 120);
      if (rx_mode == RX_HOLD && span > longest_hold) begin
        longest_hold = span;
      end
      for (int k = 0; k < span; k++) begin
        case (rx_mode)
          RX_OPEN:    out_ch.ready <= 1'b1;
          RX_RANDOM:  out_ch.ready <= 1'($urandom_range(0, 1));
          RX_PATTERN: out_ch.ready <= (k % 4 != 3);
          RX_SPARSE:  out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:    out_ch.ready <= 1'b0;
        endcase
        @(posedge clk);
      end
      stretch++;
    end
  end

  always @(posedge clk) begin
    level_set_t want;
    level_set_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.throttle_level = out_ch.throttle_level;
      got.filtered_level = out_ch.filtered_level;
      got.zero_offset    = out_ch.zero_offset;
      got.has_samples    = out_ch.has_samples;
      results_checked++;
      if (pending_levels.size() == 0) begin
        report_mismatch("result beat with nothing pending", '0, got);
      end else begin
        want = pending_levels.pop_front();
        if (got.throttle_level !== want.throttle_level) begin
          report_mismatch("throttle_level", want, got);
        end
        if (got.filtered_level !== want.filtered_level) begin
          report_mismatch("filtered_level", want, got);
        end
        if (got.zero_offset !== want.zero_offset) begin
          report_mismatch("zero_offset", want, got);
        end
        if (got.has_samples !== want.has_samples) begin
          report_mismatch("has_samples", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results pending.", cycle_count,
               pending_levels.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

FILE: throttle_filter_auto_zero.f
sv/tfaz_pkg.sv
sv/tfaz_if.sv
sv/tfaz_in_stage.sv
sv/tfaz_core.sv
sv/throttle_filter_auto_zero.sv
sim/throttle_filter_auto_zero_tb.sv
